>>> design/multires_hash_grid_features_assert.svh
// Assertion macros for the multires hash grid feature block
`ifndef MULTIRES_HASH_GRID_FEATURES_ASSERT_SVH
`define MULTIRES_HASH_GRID_FEATURES_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MHG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhg assertion failed");

// Next-cycle implication, disabled in reset
`define MHG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhg assertion failed");

`endif

>>> design/mhg_pkg.sv
// Package: constants and transaction types of the hash grid feature store
`timescale 1ns / 1ps
package mhg_pkg;
  localparam int LEVELS        = 16;
  localparam int TABLE_ENTRIES = 4096;
  localparam int LEVEL_W       = $clog2(LEVELS);
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = LEVEL_W + IDX_W;
  localparam int DEPTH         = LEVELS * TABLE_ENTRIES;

  localparam logic [31:0] PRIME_X = 32'd1;
  localparam logic [31:0] PRIME_Y = 32'd2654435761;
  localparam logic [31:0] PRIME_Z = 32'd805459861;
  localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] REG_TABLE_SIZE    = 2'd0;
  localparam logic [1:0] REG_COARSE_SCALE  = 2'd1;
  localparam logic [1:0] REG_LEVEL_GROWTH  = 2'd2;
  localparam logic [1:0] REG_LEARNING_RATE = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [3:0]         grid_level;
    logic signed [15:0] grad_a;
    logic signed [15:0] grad_b;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_level;
    logic signed [15:0] feature_a;
    logic signed [15:0] feature_b;
    logic               last;
  } out_t;

  // Status of the remainder unit
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_status_t;
endpackage

>>> design/mhg_mod_unit.sv
// Bit-serial remainder unit: 32-bit hash modulo table size, one bit per cycle
`timescale 1ns / 1ps
module mhg_mod_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               dividend,
  input  logic [mhg_pkg::IDX_W:0]   divisor,
  output mhg_pkg::mod_status_t      status
);
  logic                       busy;
  logic                       done;
  logic [4:0]                 cnt;
  logic [31:0]                shreg;
  logic [mhg_pkg::IDX_W-1:0]  rem;
  logic [mhg_pkg::IDX_W:0]    trial;

  assign trial = {rem, shreg[31]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring remainder step
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[30:0], 1'b0};
      if (trial >= divisor) begin
        rem <= mhg_pkg::IDX_W'(trial - divisor);
      end else begin
        rem <= trial[mhg_pkg::IDX_W-1:0];
      end
    end
  end

  assign status.done = done;
  assign status.rem  = rem;
endmodule

>>> design/multires_hash_grid_features.sv
// Top level: multiresolution hash grid feature store with iterative datapath
// Usage:
//  - in channel (in_valid/in_ready/in_data) takes one transaction at a time.
//    A lookup returns one out transaction per level, level 0 first, with
//    last set on the final level. An update changes one level entry and
//    returns nothing.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//    write it only while the block is idle.
//  - Each level runs 3 cell multiplies, 2 hash multiplies, the remainder
//    (32 bit steps), a table read, the emit step and a scale step for the
//    next level; level 0 needs no scale step. A lookup or an update keeps
//    in_ready low until it is through, and the remainder unit takes the
//    largest share of each level.
//  - The result register lets the datapath run ahead by one level; when
//    the receiver stalls, the sequencer holds before loading the next level.
//  - After rst the table is cleared one entry per cycle, all 65536 entries,
//    with in_ready low. Registers return to their default values at once.
`timescale 1ns / 1ps
`include "multires_hash_grid_features_assert.svh"
module multires_hash_grid_features (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mhg_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mhg_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [23:0]    cfg_data
);
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_SCL   = 5'd2;
  localparam logic [4:0] S_SCLW  = 5'd3;
  localparam logic [4:0] S_CX    = 5'd4;
  localparam logic [4:0] S_CY    = 5'd5;
  localparam logic [4:0] S_CZ    = 5'd6;
  localparam logic [4:0] S_HY    = 5'd7;
  localparam logic [4:0] S_HZ    = 5'd8;
  localparam logic [4:0] S_HF    = 5'd9;
  localparam logic [4:0] S_MOD   = 5'd10;
  localparam logic [4:0] S_RD    = 5'd11;
  localparam logic [4:0] S_EMIT  = 5'd12;
  localparam logic [4:0] S_UA    = 5'd13;
  localparam logic [4:0] S_UB    = 5'd14;
  localparam logic [4:0] S_UW    = 5'd15;

  localparam logic [mhg_pkg::LEVEL_W-1:0] LAST_LEVEL =
    mhg_pkg::LEVEL_W'(mhg_pkg::LEVELS - 1);

  // configuration
  logic [12:0] table_size;
  logic [23:0] coarse_scale;
  logic [17:0] level_growth;
  logic [15:0] learning_rate;

  // sequencer and datapath registers
  logic [4:0]                  state;
  logic [mhg_pkg::ADDR_W-1:0]  clr_cnt;
  mhg_pkg::in_t                item;
  logic [mhg_pkg::LEVEL_W-1:0] lvl;
  logic [23:0]                 scale;
  logic signed [65:0]          prod;
  logic signed [32:0]          mul_a;
  logic signed [32:0]          mul_b;
  logic [31:0]                 cx;
  logic [31:0]                 cy;
  logic [31:0]                 cz;
  logic [31:0]                 hash;
  logic [31:0]                 hash_full;
  logic [mhg_pkg::ADDR_W-1:0]  addr;
  logic [31:0]                 rdata;
  logic [15:0]                 new_a;
  logic [15:0]                 new_b;
  logic [mhg_pkg::IDX_W:0]     tsize_eff;
  mhg_pkg::mod_status_t        mod_st;
  logic                        mod_start;
  logic                        out_free;
  logic                        in_acc;
  logic [mhg_pkg::LEVEL_W-1:0] target;

  logic [31:0] mem [mhg_pkg::DEPTH];

  // saturating feature step: f - round(prod / 2^16)
  function automatic logic [15:0] step_feature(input logic [15:0] f,
                                               input logic signed [65:0] p);
    logic signed [33:0] sum;
    logic signed [17:0] delta;
    logic signed [18:0] r;
    sum   = p[33:0] + 34'sd32768;
    delta = sum[33:16];
    r     = {{3{f[15]}}, f} - {delta[17], delta};
    if (r > 19'sd32767) begin
      return 16'h7FFF;
    end else if (r < -19'sd32768) begin
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign target    = item.grid_level[mhg_pkg::LEVEL_W-1:0];
  assign hash_full = hash ^ prod[31:0];
  assign mod_start = (state == S_HF);

  // effective table size, clamped to 1..TABLE_ENTRIES
  always_comb begin
    if (table_size == 13'd0) begin
      tsize_eff = (mhg_pkg::IDX_W + 1)'(1);
    end else if (32'(table_size) > 32'(mhg_pkg::TABLE_ENTRIES)) begin
      tsize_eff = (mhg_pkg::IDX_W + 1)'(mhg_pkg::TABLE_ENTRIES);
    end else begin
      tsize_eff = (mhg_pkg::IDX_W + 1)'(table_size);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size    <= 13'd4096;
      coarse_scale  <= 24'd65536;
      level_growth  <= 18'd98304;
      learning_rate <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mhg_pkg::REG_TABLE_SIZE:    table_size    <= cfg_data[12:0];
        mhg_pkg::REG_COARSE_SCALE:  coarse_scale  <= cfg_data;
        mhg_pkg::REG_LEVEL_GROWTH:  level_growth  <= cfg_data[17:0];
        mhg_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CX: begin
        mul_a = {item.pos_x[31], item.pos_x};
        mul_b = {9'd0, scale};
      end
      S_CY: begin
        mul_a = {item.pos_y[31], item.pos_y};
        mul_b = {9'd0, scale};
      end
      S_CZ: begin
        mul_a = {item.pos_z[31], item.pos_z};
        mul_b = {9'd0, scale};
      end
      S_HY: begin
        mul_a = {1'b0, cy};
        mul_b = {1'b0, mhg_pkg::PRIME_Y};
      end
      S_HZ: begin
        mul_a = {1'b0, cz};
        mul_b = {1'b0, mhg_pkg::PRIME_Z};
      end
      S_SCL: begin
        mul_a = {9'd0, scale};
        mul_b = {15'd0, level_growth};
      end
      S_UA: begin
        mul_a = {{17{item.grad_a[15]}}, item.grad_a};
        mul_b = {17'd0, learning_rate};
      end
      S_UB: begin
        mul_a = {{17{item.grad_b[15]}}, item.grad_b};
        mul_b = {17'd0, learning_rate};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  mhg_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash_full),
    .divisor  (tsize_eff),
    .status   (mod_st)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit state reloads the result register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + mhg_pkg::ADDR_W'(1);
          if (clr_cnt == mhg_pkg::ADDR_W'(mhg_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            item  <= in_data;
            lvl   <= '0;
            scale <= coarse_scale;
            if (in_data.operation == mhg_pkg::OP_LOOKUP) begin
              state <= S_CX;
            end else if (5'(in_data.grid_level) > 5'(LAST_LEVEL)) begin
              state <= S_IDLE;
            end else if (in_data.grid_level == 4'd0) begin
              state <= S_CX;
            end else begin
              state <= S_SCL;
            end
          end
        end
        S_SCL: state <= S_SCLW;
        S_SCLW: begin
          if (prod[41:40] != 2'b00) begin
            scale <= mhg_pkg::SCALE_MAX;
          end else begin
            scale <= prod[39:16];
          end
          lvl <= lvl + mhg_pkg::LEVEL_W'(1);
          if (item.operation == mhg_pkg::OP_LOOKUP ||
              lvl + mhg_pkg::LEVEL_W'(1) == target) begin
            state <= S_CX;
          end else begin
            state <= S_SCL;
          end
        end
        S_CX: state <= S_CY;
        S_CY: begin
          cx    <= prod[63:32];
          state <= S_CZ;
        end
        S_CZ: begin
          cy    <= prod[63:32];
          state <= S_HY;
        end
        S_HY: begin
          cz    <= prod[63:32];
          state <= S_HZ;
        end
        S_HZ: begin
          hash  <= cx ^ prod[31:0];
          state <= S_HF;
        end
        S_HF: state <= S_MOD;
        S_MOD: begin
          if (mod_st.done) begin
            addr  <= {lvl, mod_st.rem};
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (item.operation == mhg_pkg::OP_LOOKUP) ? S_EMIT : S_UA;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_data.out_level <= 4'(lvl);
            out_data.feature_a <= rdata[15:0];
            out_data.feature_b <= rdata[31:16];
            out_data.last      <= (lvl == LAST_LEVEL);
            state              <= (lvl == LAST_LEVEL) ? S_IDLE : S_SCL;
          end
        end
        S_UA: state <= S_UB;
        S_UB: begin
          new_a <= step_feature(rdata[15:0], prod);
          state <= S_UW;
        end
        S_UW: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign new_b = step_feature(rdata[31:16], prod);

  // feature table: one write port (clear or update), one registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_cnt] <= 32'd0;
    end else if (state == S_UW) begin
      mem[addr] <= {new_b, new_a};
    end
    if (state == S_RD) begin
      rdata <= mem[addr];
    end
  end

  // checks
  `MHG_ASSERT_IMP(a_rem_in_range, clk, rst, mod_st.done,
                  (mhg_pkg::IDX_W + 1)'(mod_st.rem) < tsize_eff)
  `MHG_ASSERT_IMP(a_last_level, clk, rst, out_valid && out_data.last,
                  out_data.out_level == 4'(LAST_LEVEL))
  `MHG_ASSERT_NEXT(a_no_accept_busy, clk, rst, in_acc, !in_ready)
endmodule
